[rtl/core/dtoc_pkg.sv]
// ----------------------------------------------------------------------------
// dtoc_pkg: shared definitions for the decimal text to ones' complement block
// Character codes, status codes, field widths, the snapshot record passed
// from the accumulator to the formatter, and constant tables for the fraction.
// ----------------------------------------------------------------------------
`default_nettype none

package dtoc_pkg;

    localparam int INT_W       = 32;
    localparam int FRAC_OUT_W  = 4;
    localparam int FRAC_DIGITS = 9;
    localparam int FRAC_W      = 30;
    localparam int CNT_W       = 4;
    localparam int LEN_W       = 6;
    localparam int STAT_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int FRAC_STEPS  = (1 << FRAC_OUT_W) - 1;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
    localparam logic [STAT_W-1:0] ST_SAT = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD = 2'd2;

    // Final state of one number, handed from the accumulator to the formatter.
    typedef struct packed {
        logic                negative;
        logic [INT_W-1:0]    int_val;
        logic                has_point;
        logic [FRAC_W-1:0]   frac_val;
        logic [STAT_W-1:0]   status;
    } t_number;

    typedef logic [FRAC_W-1:0] t_weight_tab [FRAC_DIGITS];
    typedef logic [FRAC_W-1:0] t_thresh_tab [FRAC_STEPS];

    // Fraction digit k carries weight 10^(FRAC_DIGITS-1-k), so the fraction
    // is always held scaled by 10^FRAC_DIGITS no matter how many digits came.
    function automatic t_weight_tab build_weights();
        t_weight_tab tab;
        longint      p;
        p = 1;
        for (int k = FRAC_DIGITS - 1; k >= 0; k--) begin
            tab[k] = FRAC_W'(p);
            p      = p * 10;
        end
        return tab;
    endfunction

    // Entry i is the smallest scaled fraction whose binary fraction is i+1.
    function automatic t_thresh_tab build_thresholds();
        t_thresh_tab tab;
        longint      scale;
        longint      t;
        scale = 1;
        for (int k = 0; k < FRAC_DIGITS; k++) begin
            scale = scale * 10;
        end
        for (int i = 0; i < FRAC_STEPS; i++) begin
            t      = (longint'(i + 1) * scale + (longint'(1) << FRAC_OUT_W) - 1) >> FRAC_OUT_W;
            tab[i] = FRAC_W'(t);
        end
        return tab;
    endfunction

    localparam t_weight_tab FRAC_WEIGHT = build_weights();
    localparam t_thresh_tab FRAC_THRESH = build_thresholds();

endpackage

`default_nettype wire

[rtl/core/dtoc_accum.sv]
// ----------------------------------------------------------------------------
// dtoc_accum: character register and number accumulator
// Registers each incoming character, folds it into the sign, integer and
// fraction state, and on the final character captures a snapshot of the
// number and returns the state to its reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module dtoc_accum import dtoc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire logic              i_last_char,
    output logic                   o_snap_valid,
    input  wire logic              i_snap_ready,
    output t_number                o_snap
);

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;

    logic              r_sign, n_sign;
    logic              r_point, n_point;
    logic [INT_W-1:0]  r_int, n_int;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [STAT_W-1:0] r_err, n_err;

    logic              r_snap_valid;
    t_number           r_snap;

    logic               move;
    logic               snap_free;
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
    logic [INT_W+3:0]   int_wide;
    logic               frac_room;
    logic [CNT_W-1:0]   weight_idx;
    logic [FRAC_W+3:0]  frac_prod;

    // A word without the last mark never needs the snapshot register.
    assign snap_free = !r_snap_valid || i_snap_ready;
    assign move      = r_in_valid && (!r_in_last || snap_free);
    assign o_ready   = !r_in_valid || move;

    // The low nibble of an ASCII digit is its value.
    assign is_digit = (r_in_char >= CH_ZERO) && (r_in_char <= CH_NINE);
    assign digit    = r_in_char[DIGIT_W-1:0];

    // Ten times the integer plus the digit; any carry above INT_W overflows.
    assign int_wide = ({4'b0, r_int} << 3) + ({4'b0, r_int} << 1)
                    + {{INT_W{1'b0}}, digit};

    assign frac_room  = r_count < CNT_W'(FRAC_DIGITS);
    assign weight_idx = frac_room ? r_count : '0;
    assign frac_prod  = {4'b0, FRAC_WEIGHT[weight_idx]} * {{FRAC_W{1'b0}}, digit};

    always_comb begin
        n_sign  = r_sign;
        n_point = r_point;
        n_int   = r_int;
        n_frac  = r_frac;
        n_count = r_count;
        n_err   = r_err;
        priority if (r_in_char == CH_MINUS || r_in_char == CH_PLUS) begin
            n_sign  = (r_in_char == CH_MINUS);
            n_point = 1'b0;
            n_int   = '0;
            n_frac  = '0;
            n_count = '0;
        end else if (r_in_char == CH_POINT && !r_point) begin
            n_point = 1'b1;
        end else if (is_digit) begin
            if (!r_point) begin
                if (int_wide[INT_W+3:INT_W] != 4'b0) begin
                    n_int = '1;
                    if (r_err == ST_OK) begin
                        n_err = ST_SAT;
                    end
                end else begin
                    n_int = int_wide[INT_W-1:0];
                end
            end else if (frac_room) begin
                n_frac  = r_frac + frac_prod[FRAC_W-1:0];
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            n_err = ST_BAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_snap_valid <= 1'b0;
            r_sign       <= 1'b0;
            r_point      <= 1'b0;
            r_int        <= '0;
            r_frac       <= '0;
            r_count      <= '0;
            r_err        <= ST_OK;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (move) begin
                if (r_in_last) begin
                    r_sign  <= 1'b0;
                    r_point <= 1'b0;
                    r_int   <= '0;
                    r_frac  <= '0;
                    r_count <= '0;
                    r_err   <= ST_OK;
                end else begin
                    r_sign  <= n_sign;
                    r_point <= n_point;
                    r_int   <= n_int;
                    r_frac  <= n_frac;
                    r_count <= n_count;
                    r_err   <= n_err;
                end
            end
            if (move && r_in_last) begin
                r_snap_valid <= 1'b1;
            end else if (i_snap_ready) begin
                r_snap_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last_char;
        end
        if (move && r_in_last) begin
            r_snap.negative  <= n_sign;
            r_snap.int_val   <= n_int;
            r_snap.has_point <= n_point;
            r_snap.frac_val  <= n_frac;
            r_snap.status    <= n_err;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule

`default_nettype wire

[rtl/core/dtoc_format.sv]
// ----------------------------------------------------------------------------
// dtoc_format: result formatter and output register
// Finds the significant length of the integer, applies the ones' complement
// within that length to negative numbers, converts the scaled decimal fraction
// to binary fraction bits, and holds the result word until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dtoc_format import dtoc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire t_number            i_number,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_negative,
    output logic [INT_W-1:0]        o_int_bits,
    output logic [LEN_W-1:0]        o_int_length,
    output logic                    o_has_fraction,
    output logic [FRAC_OUT_W-1:0]   o_frac_bits,
    output logic [STAT_W-1:0]       o_status
);

    logic                  r_valid;
    logic                  r_negative;
    logic [INT_W-1:0]      r_int_bits;
    logic [LEN_W-1:0]      r_int_length;
    logic                  r_has_fraction;
    logic [FRAC_OUT_W-1:0] r_frac_bits;
    logic [STAT_W-1:0]     r_status;

    logic [INT_W-1:0]      len_mask;
    logic [LEN_W-1:0]      len;
    logic [FRAC_OUT_W-1:0] frac_mag;
    logic [FRAC_OUT_W-1:0] frac_out;
    logic [INT_W-1:0]      bits_out;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        // Ones at and below the highest set bit of the integer.
        len_mask[INT_W-1] = i_number.int_val[INT_W-1];
        for (int k = INT_W - 2; k >= 0; k--) begin
            len_mask[k] = len_mask[k+1] | i_number.int_val[k];
        end
        len = '0;
        for (int k = 0; k < INT_W; k++) begin
            if (i_number.int_val[k]) begin
                len = LEN_W'(k + 1);
            end
        end
        bits_out = i_number.int_val ^ (i_number.negative ? len_mask : '0);

        // The thresholds rise, so the last one passed gives the fraction bits.
        frac_mag = '0;
        for (int i = 0; i < FRAC_STEPS; i++) begin
            if (i_number.frac_val >= FRAC_THRESH[i]) begin
                frac_mag = FRAC_OUT_W'(i + 1);
            end
        end
        if (!i_number.has_point) begin
            frac_out = '0;
        end else if (i_number.negative) begin
            frac_out = ~frac_mag;
        end else begin
            frac_out = frac_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_negative     <= i_number.negative;
            r_int_bits     <= bits_out;
            r_int_length   <= len;
            r_has_fraction <= i_number.has_point;
            r_frac_bits    <= frac_out;
            r_status       <= i_number.status;
        end
    end

    assign o_valid        = r_valid;
    assign o_negative     = r_negative;
    assign o_int_bits     = r_int_bits;
    assign o_int_length   = r_int_length;
    assign o_has_fraction = r_has_fraction;
    assign o_frac_bits    = r_frac_bits;
    assign o_status       = r_status;

endmodule

`default_nettype wire

[rtl/core/decimal_text_to_ones_complement_binary_top.sv]
// After its final character is accepted, a result word passes the snapshot register
// and the formatter's output register. Throughput: one character per cycle unless
// a final character waits for the snapshot register; multiply-by-ten is one loop.
// Only characters marked last produce a result word; others produce none.
// Reset is synchronous and active low; it clears all number state and empties
// every stage, and the block can take a character in the first cycle after it.
// ----------------------------------------------------------------------------
// decimal_text_to_ones_complement_binary_top: ASCII decimal to binary converter
// Streams the characters of a signed decimal number and returns its integer
// and fraction bits in ones' complement form with a status code.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_text_to_ones_complement_binary_top import dtoc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [CHAR_W-1:0]     i_char_code,
    input  wire logic                  i_last_char,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_negative,
    output logic [INT_W-1:0]           o_int_bits,
    output logic [LEN_W-1:0]           o_int_length,
    output logic                       o_has_fraction,
    output logic [FRAC_OUT_W-1:0]      o_frac_bits,
    output logic [STAT_W-1:0]          o_status
);

    logic    snap_valid;
    logic    snap_ready;
    t_number snap;

    dtoc_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_char_code  (i_char_code),
        .i_last_char  (i_last_char),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap)
    );

    dtoc_format u_format (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (snap_valid),
        .o_ready        (snap_ready),
        .i_number       (snap),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_negative     (o_negative),
        .o_int_bits     (o_int_bits),
        .o_int_length   (o_int_length),
        .o_has_fraction (o_has_fraction),
        .o_frac_bits    (o_frac_bits),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire

[rtl/core/dtoc_checker.sv]
// ----------------------------------------------------------------------------
// dtoc_port_checker: port-level checks for the converter
// Watches the top-level ports and flags words that break either handshake
// or result words that carry inconsistent fields.
// ----------------------------------------------------------------------------
`default_nettype none

module dtoc_port_checker import dtoc_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_ready,
    input wire logic [CHAR_W-1:0]     i_char_code,
    input wire logic                  i_last_char,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire logic                  o_negative,
    input wire logic [INT_W-1:0]      o_int_bits,
    input wire logic [LEN_W-1:0]      o_int_length,
    input wire logic                  o_has_fraction,
    input wire logic [FRAC_OUT_W-1:0] o_frac_bits,
    input wire logic [STAT_W-1:0]     o_status
);

    // A character word that is refused must be offered again unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid
            && $stable({i_char_code, i_last_char}))
        else $error("character word changed while stalled");

    // A stalled result word must hold until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable({o_negative, o_int_bits, o_int_length,
                        o_has_fraction, o_frac_bits, o_status}))
        else $error("result word changed while stalled");

    // A positive integer has no bits above its significant length.
    a_pos_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_negative |-> o_int_length <= LEN_W'(INT_W)
            && (o_int_bits >> o_int_length) == '0)
        else $error("integer bits exceed reported length");

    // Without a decimal point the fraction bits are zero even for negatives.
    a_no_point_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_fraction |-> o_frac_bits == '0)
        else $error("fraction bits set without a point");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == ST_OK || o_status == ST_SAT || o_status == ST_BAD)
        else $error("undefined status code");

endmodule

bind decimal_text_to_ones_complement_binary_top dtoc_port_checker u_dtoc_port_checker (.*);

`default_nettype wire

[sim/dtoc_checker.sv]
// ----------------------------------------------------------------------------
// dtoc_checker: scoreboard for the decimal text to ones' complement converter
// Watches both channels, rebuilds each number from the accepted characters,
// forms the expected result word when the final character goes in, and
// compares every accepted result word with the oldest pending prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module dtoc_checker import dtoc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic [CHAR_W-1:0]     i_char_code,
    input  wire logic                  i_last_char,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic                  i_negative,
    input  wire logic [INT_W-1:0]      i_int_bits,
    input  wire logic [LEN_W-1:0]      i_int_length,
    input  wire logic                  i_has_fraction,
    input  wire logic [FRAC_OUT_W-1:0] i_frac_bits,
    input  wire logic [STAT_W-1:0]     i_status,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct packed {
        logic                  negative;
        logic [INT_W-1:0]      int_bits;
        logic [LEN_W-1:0]      int_length;
        logic                  has_fraction;
        logic [FRAC_OUT_W-1:0] frac_bits;
        logic [STAT_W-1:0]     status;
    } t_conv_word;

    localparam longint unsigned INT_LIMIT = (64'd1 << INT_W) - 1;

    // Number under construction.
    logic              num_sign;
    logic              num_point;
    longint unsigned   num_int;
    longint unsigned   num_frac;
    int                num_fdigits;
    logic [STAT_W-1:0] num_status;

    t_conv_word awaited_words[$];
    int         mismatches = 0;

    task automatic clear_number();
        num_point   = 1'b0;
        num_int     = 0;
        num_frac    = 0;
        num_fdigits = 0;
    endtask

    task automatic forget_number();
        num_sign   = 1'b0;
        num_status = ST_OK;
        clear_number();
    endtask

    task automatic absorb_char(input logic [CHAR_W-1:0] c);
        longint unsigned d;
        if (c == CH_MINUS || c == CH_PLUS) begin
            num_sign = (c == CH_MINUS);
            clear_number();
        end else if (c == CH_POINT && !num_point) begin
            num_point = 1'b1;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 64'(c - CH_ZERO);
            if (!num_point) begin
                // Saturate instead of wrapping; an invalid status is never downgraded.
                if (num_int > (INT_LIMIT - d) / 10) begin
                    num_int = INT_LIMIT;
                    if (num_status == ST_OK) num_status = ST_SAT;
                end else begin
                    num_int = num_int * 10 + d;
                end
            end else if (num_fdigits < FRAC_DIGITS) begin
                num_frac    = num_frac * 10 + d;
                num_fdigits = num_fdigits + 1;
            end
        end else begin
            num_status = ST_BAD;
        end
    endtask

    function automatic t_conv_word format_number();
        t_conv_word            w;
        longint unsigned       v;
        longint unsigned       scale;
        longint unsigned       rem;
        int                    len;
        logic [FRAC_OUT_W-1:0] fb;
        len = 0;
        for (v = num_int; v != 0; v = v >> 1) len++;
        w.negative   = num_sign;
        w.int_bits   = INT_W'(num_int);
        if (num_sign && len != 0) w.int_bits = w.int_bits ^ INT_W'((64'd1 << len) - 1);
        w.int_length = LEN_W'(len);
        w.has_fraction = num_point;
        fb = '0;
        if (num_point) begin
            // Long division of the decimal fraction by its own scale, one bit at a time.
            scale = 1;
            for (int k = 0; k < num_fdigits; k++) scale = scale * 10;
            rem = num_frac;
            for (int k = 0; k < FRAC_OUT_W; k++) begin
                rem = rem << 1;
                fb  = fb << 1;
                if (rem >= scale) begin
                    rem   = rem - scale;
                    fb[0] = 1'b1;
                end
            end
            if (num_sign) fb = ~fb;
        end
        w.frac_bits = fb;
        w.status    = num_status;
        return w;
    endfunction

    task automatic cmp_field(input string name, input longint unsigned want,
                             input longint unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_conv_word want;
        if (!i_rst_n) begin
            forget_number();
            awaited_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result word with nothing pending: int_bits %h status %0d",
                                 i_int_bits, i_status);
                end else begin
                    want = awaited_words.pop_front();
                    cmp_field("negative", want.negative, i_negative);
                    cmp_field("int_bits", want.int_bits, i_int_bits);
                    cmp_field("int_length", want.int_length, i_int_length);
                    cmp_field("has_fraction", want.has_fraction, i_has_fraction);
                    cmp_field("frac_bits", want.frac_bits, i_frac_bits);
                    cmp_field("status", want.status, i_status);
                end
            end
            if (i_in_valid && i_in_ready) begin
                absorb_char(i_char_code);
                if (i_last_char) begin
                    awaited_words.push_back(format_number());
                    forget_number();
                end
            end
        end
        o_pending    <= awaited_words.size();
        o_fail_count <= mismatches;
    end

endmodule

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the decimal text to ones' complement converter
// Feeds directed and random number text with random gaps and output stalls,
// including a long output hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import dtoc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int TEXT_CHARS  = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [CHAR_W-1:0]     char_code;
    logic                  last_char;
    logic                  out_valid;
    logic                  out_ready;
    logic                  negative;
    logic [INT_W-1:0]      int_bits;
    logic [LEN_W-1:0]      int_length;
    logic                  has_fraction;
    logic [FRAC_OUT_W-1:0] frac_bits;
    logic [STAT_W-1:0]     status;

    int fail_count;
    int pending;
    bit gaps_on    = 1'b1;
    int hold_seq   = 0;
    int chars_sent = 0;
    int cycles     = 0;

    decimal_text_to_ones_complement_binary_top uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_char_code    (char_code),
        .i_last_char    (last_char),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_negative     (negative),
        .o_int_bits     (int_bits),
        .o_int_length   (int_length),
        .o_has_fraction (has_fraction),
        .o_frac_bits    (frac_bits),
        .o_status       (status)
    );

    dtoc_checker chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_char_code    (char_code),
        .i_last_char    (last_char),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_negative     (negative),
        .i_int_bits     (int_bits),
        .i_int_length   (int_length),
        .i_has_fraction (has_fraction),
        .i_frac_bits    (frac_bits),
        .i_status       (status),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Output side: random stalls, plus a long hold-off whenever hold_seq moves.
    initial begin : sink
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !(gaps_on && $urandom_range(99) < 27);
            end
        end
    end

    // Valid stays high from one word to the next unless a gap is taken.
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic closes);
        while (gaps_on && $urandom_range(99) < 27) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        last_char <= closes;
        do @(posedge clk); while (!in_ready);
        chars_sent++;
    endtask

    task automatic send_str(input string s, input bit closes);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], closes && (i == s.len() - 1));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_random_number();
        logic [CHAR_W-1:0] txt[$];
        string             near_max;
        string             pool;
        int                n;
        bit                near;
        near_max = "42949672";
        pool     = "+-.0123456789";
        if ($urandom_range(99) < 82) begin
            // Well-formed number with random content, now and then corrupted.
            case ($urandom_range(2))
                1: txt.push_back(CH_PLUS);
                2: txt.push_back(CH_MINUS);
                default: ;
            endcase
            n    = ($urandom_range(3) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 9);
            near = (n >= 10) && ($urandom_range(1) == 1);
            for (int i = 0; i < n; i++) begin
                if (near && i < 8) txt.push_back(near_max[i]);
                else txt.push_back(CHAR_W'(CH_ZERO + $urandom_range(9)));
            end
            if ($urandom_range(1)) begin
                txt.push_back(CH_POINT);
                n = ($urandom_range(3) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5);
                for (int i = 0; i < n; i++) txt.push_back(CHAR_W'(CH_ZERO + $urandom_range(9)));
            end
            if (txt.size() == 0) txt.push_back(CHAR_W'(CH_ZERO + $urandom_range(9)));
            if ($urandom_range(9) == 0)
                txt.insert($urandom_range(txt.size()),
                           $urandom_range(1) ? CHAR_W'($urandom_range(255))
                                             : pool[$urandom_range(pool.len() - 1)]);
        end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                txt.push_back($urandom_range(1) ? CHAR_W'($urandom_range(255))
                                                : pool[$urandom_range(pool.len() - 1)]);
        end
        foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        char_code = '0;
        last_char = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: bare sign, first overflowing integer, sign after digits with
        // an empty fraction, an exact fraction, and invalid characters.
        send_str("-", 1'b1);
        send_str("4294967296", 1'b1);
        send_str("9+-.", 1'b1);
        send_str("1.0625", 1'b1);
        send_str("3.", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(CH_POINT, 1'b0);
        send_char(8'hFF, 1'b1);
        wait_drained();

        // Hold the output while short numbers keep coming so the block backs up.
        gaps_on  <= 1'b0;
        hold_seq <= hold_seq + 1;
        repeat (40) send_char(CHAR_W'(CH_ZERO + $urandom_range(9)), 1'b1);
        wait_drained();

        while (chars_sent < TEXT_CHARS) begin
            gaps_on <= !(chars_sent >= 900 && chars_sent < 1200);
            send_random_number();
            if ($urandom_range(49) == 0) wait_drained();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/core/dtoc_pkg.sv
rtl/core/dtoc_accum.sv
rtl/core/dtoc_format.sv
rtl/core/decimal_text_to_ones_complement_binary_top.sv
rtl/core/dtoc_checker.sv
sim/dtoc_checker.sv
sim/tb_top.sv
